>>> rtl/core/dst_pkg.sv
// ----------------------------------------------------------------------------
// Date set table package
// Shared types, codes and helpers for the packed date table.
// ----------------------------------------------------------------------------
package dst_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int CNT_W         = 6;
   localparam int DAY_W         = 5;
   localparam int MONTH_W       = 4;
   localparam int YEAR_W        = 7;
   localparam int DATE_W        = DAY_W + MONTH_W + YEAR_W;

   localparam logic [DAY_W-1:0]   MAX_DAY   = DAY_W'(31);
   localparam logic [MONTH_W-1:0] MAX_MONTH = MONTH_W'(12);
   localparam logic [YEAR_W-1:0]  MAX_YEAR  = YEAR_W'(99);

   typedef enum logic [2:0] {
      FN_ADD     = 3'd0,
      FN_RM_DATE = 3'd1,
      FN_LOOKUP  = 3'd2,
      FN_READ    = 3'd3,
      FN_RM_IDX  = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_FULL     = 3'd2,
      ST_PRESENT  = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHF_RD,
      S_SHF_WR,
      S_FETCH,
      S_READ_OUT
   } state_type;

   // day in the low bits, then month, then year
   function automatic logic [DATE_W-1:0] pack_date(input logic [DAY_W-1:0]   d,
                                                   input logic [MONTH_W-1:0] m,
                                                   input logic [YEAR_W-1:0]  y);
      pack_date = {y, m, d};
   endfunction

   function automatic logic date_ok(input logic [DAY_W-1:0]   d,
                                    input logic [MONTH_W-1:0] m,
                                    input logic [YEAR_W-1:0]  y);
      date_ok = (d != '0) && (d <= MAX_DAY) && (m != '0) && (m <= MAX_MONTH)
                && (y <= MAX_YEAR);
   endfunction

endpackage

>>> rtl/core/date_set_table_top.sv
// ----------------------------------------------------------------------------
// Date set table
// Packed table of distinct dates with add, remove, lookup and read commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its single result
// appears on the rsp_ ports for one cycle with rsp_valid and cannot be held
// off. The table lives in one single-port memory with a registered read, so
// a search reads and then compares each stored entry, and a compaction reads
// each entry above the removed one and writes it one place down. A rejected
// add, an out-of-range slot or an unused code answers straight from idle; a
// read at index fetches the slot and then answers; add, lookup and remove by
// date search the stored entries, and remove by date then compacts; remove at
// index compacts the entries above the slot. busy stays high until the result
// is issued.
module date_set_table_top #(
   parameter int TABLE_DEPTH = dst_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_func,
   input  logic [dst_pkg::DAY_W-1:0]   req_day,
   input  logic [dst_pkg::MONTH_W-1:0] req_month,
   input  logic [dst_pkg::YEAR_W-1:0]  req_year,
   input  logic [dst_pkg::CNT_W-1:0]   req_slot,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_found,
   output logic [dst_pkg::DAY_W-1:0]   rsp_out_day,
   output logic [dst_pkg::MONTH_W-1:0] rsp_out_month,
   output logic [dst_pkg::YEAR_W-1:0]  rsp_out_year,
   output logic [dst_pkg::CNT_W-1:0]   rsp_entries_used
);
   import dst_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   state_type           state_ff, state_in;
   func_type            func_ff, func_in;
   logic [DATE_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    ptr_inc;

   logic [DATE_W-1:0]   mem [TABLE_DEPTH];
   logic [DATE_W-1:0]   rd_data_ff;
   logic                rd_en, wr_en;
   logic [IDX_W-1:0]    rd_addr, wr_addr;
   logic [DATE_W-1:0]   wr_data;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [DATE_W-1:0]   rsp_date_ff, rsp_date_in;
   logic [CNT_W-1:0]    rsp_used_ff;

   logic                accept;
   logic                match;
   logic                req_date_ok;
   logic                table_full;
   logic                slot_hit;
   func_type            req_fn;

   assign accept      = start && !busy;
   assign req_fn      = func_type'(req_func);
   assign match       = (rd_data_ff == key_ff);
   assign ptr_inc     = ptr_ff + CNT_W'(1);
   assign req_date_ok = date_ok(req_day, req_month, req_year);
   assign table_full  = (count_ff >= DEPTH_CNT);
   assign slot_hit    = (req_slot < count_ff) && (req_slot < DEPTH_CNT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_fn)
                  FN_ADD:     state_in = (req_date_ok && !table_full) ? S_SRCH_RD : S_IDLE;
                  FN_RM_DATE: state_in = S_SRCH_RD;
                  FN_LOOKUP:  state_in = S_SRCH_RD;
                  FN_READ:    state_in = slot_hit ? S_FETCH : S_IDLE;
                  FN_RM_IDX:  state_in = slot_hit ? S_SHF_RD : S_IDLE;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_SRCH_RD:  state_in = (ptr_ff >= count_ff) ? S_IDLE : S_SRCH_CMP;
         S_SRCH_CMP: begin
            if (!match) begin
               state_in = S_SRCH_RD;
            end else if (func_ff == FN_RM_DATE) begin
               state_in = S_SHF_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SHF_RD:   state_in = (ptr_inc >= count_ff) ? S_IDLE : S_SHF_WR;
         S_SHF_WR:   state_in = S_SHF_RD;
         S_FETCH:    state_in = S_READ_OUT;
         S_READ_OUT: state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      func_in       = func_ff;
      key_in        = key_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = ptr_ff[IDX_W-1:0];
      wr_data       = rd_data_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_found_in  = 1'b0;
      rsp_date_in   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = req_fn;
               key_in  = pack_date(req_day, req_month, req_year);
               ptr_in  = '0;
               case (req_fn)
                  FN_ADD: begin
                     if (!req_date_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_INVALID;
                     end else if (table_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end
                  end
                  FN_RM_DATE, FN_LOOKUP: begin
                  end
                  FN_READ, FN_RM_IDX: begin
                     ptr_in = req_slot;
                     if (!slot_hit) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOTFOUND;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_SRCH_RD: begin
            if (ptr_ff >= count_ff) begin
               // search ran off the end: no match
               rsp_valid_in = 1'b1;
               case (func_ff)
                  FN_ADD: begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IDX_W-1:0];
                     wr_data  = key_ff;
                     count_in = count_ff + CNT_W'(1);
                  end
                  FN_RM_DATE: rsp_status_in = ST_NOTFOUND;
                  default:    rsp_status_in = ST_OK;
               endcase
            end else begin
               rd_en = 1'b1;
            end
         end
         S_SRCH_CMP: begin
            if (!match) begin
               ptr_in = ptr_inc;
            end else begin
               case (func_ff)
                  FN_ADD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_PRESENT;
                  end
                  FN_LOOKUP: begin
                     rsp_valid_in = 1'b1;
                     rsp_found_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SHF_RD: begin
            if (ptr_inc >= count_ff) begin
               count_in     = count_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_inc[IDX_W-1:0];
            end
         end
         S_SHF_WR: begin
            // move the next entry down one place
            wr_en  = 1'b1;
            ptr_in = ptr_inc;
         end
         S_FETCH: rd_en = 1'b1;
         S_READ_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_date_in  = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_OK;
         rsp_found_ff  <= 1'b0;
         rsp_date_ff   <= '0;
         rsp_used_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_date_ff   <= rsp_date_in;
         rsp_used_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      key_ff  <= key_in;
      ptr_ff  <= ptr_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_out_day      = rsp_date_ff[DAY_W-1:0];
   assign rsp_out_month    = rsp_date_ff[DAY_W+MONTH_W-1:DAY_W];
   assign rsp_out_year     = rsp_date_ff[DATE_W-1:DAY_W+MONTH_W];
   assign rsp_entries_used = rsp_used_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("occupancy beyond table depth");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result issued while a command is still in flight");

   a_count_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> rsp_valid_ff)
      else $error("occupancy changed without a result beat");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_found_ff |-> (rsp_valid_ff && (rsp_status_ff == ST_OK)))
      else $error("found flag outside a successful lookup beat");

   a_used_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_used_ff == count_ff))
      else $error("reported occupancy differs from the table count");

endmodule

>>> tb/sv/date_set_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date set table testbench
// The run starts with a short table of commands that covers the field
// extremes, every operation and every error status but full. Random command
// mixes follow, alternating between filling and draining phases so that the
// table reaches full and empty again and again. A shadow copy of the table
// gives the expected response of every command that has none typed in.
// ----------------------------------------------------------------------------
module date_set_table_top_tb;
   import dst_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int RAND_ITEMS   = 800;
   localparam int PHASE_ITEMS  = 100;
   localparam int MAX_GAP      = 19;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 80;
   localparam int REPORT_MAX   = 10;
   localparam logic [2:0] FN_SPARE_MIN = 3'd5;
   localparam logic [2:0] FN_SPARE_MAX = 3'd7;

   typedef struct packed {
      logic [2:0]         func;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [CNT_W-1:0]   slot;
   } date_cmd_type;

   typedef struct packed {
      status_type         status;
      logic               found;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [CNT_W-1:0]   used;
   } date_rsp_type;

   typedef struct {
      date_cmd_type cmd;
      bit           typed;
      date_rsp_type rsp;
   } cmd_row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_func = '0;
   logic [DAY_W-1:0]   req_day = '0;
   logic [MONTH_W-1:0] req_month = '0;
   logic [YEAR_W-1:0]  req_year = '0;
   logic [CNT_W-1:0]   req_slot = '0;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic               rsp_found;
   logic [DAY_W-1:0]   rsp_out_day;
   logic [MONTH_W-1:0] rsp_out_month;
   logic [YEAR_W-1:0]  rsp_out_year;
   logic [CNT_W-1:0]   rsp_entries_used;

   logic [DATE_W-1:0] shadow_dates [DEPTH];
   int                shadow_used = 0;
   date_rsp_type      pending_rsps [$];
   cmd_row_type       cmd_rows [$];
   int                mismatches = 0;

   date_set_table_top #(.TABLE_DEPTH(DEPTH)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_day          (req_day),
      .req_month        (req_month),
      .req_year         (req_year),
      .req_slot         (req_slot),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_out_day      (rsp_out_day),
      .rsp_out_month    (rsp_out_month),
      .rsp_out_year     (rsp_out_year),
      .rsp_entries_used (rsp_entries_used)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---- shadow table ----

   function automatic int find_date(logic [DATE_W-1:0] key);
      for (int i = 0; i < shadow_used; i++) begin
         if (shadow_dates[i] == key) return i;
      end
      return shadow_used;
   endfunction

   function automatic void drop_date_at(int pos);
      for (int i = pos; i + 1 < shadow_used; i++) begin
         shadow_dates[i] = shadow_dates[i + 1];
      end
      shadow_used--;
   endfunction

   function automatic date_rsp_type apply_date_cmd(date_cmd_type c);
      date_rsp_type      r;
      logic [DATE_W-1:0] key;
      logic [DATE_W-1:0] e;
      int                pos;
      r = '0;
      r.status = ST_OK;
      key = {c.year, c.month, c.day};
      case (c.func)
         FN_ADD: begin
            if (c.day == '0 || c.day > MAX_DAY || c.month == '0 || c.month > MAX_MONTH
                || c.year > MAX_YEAR)
               r.status = ST_INVALID;
            else if (shadow_used >= DEPTH)
               r.status = ST_FULL;
            else if (find_date(key) < shadow_used)
               r.status = ST_PRESENT;
            else begin
               shadow_dates[shadow_used] = key;
               shadow_used++;
            end
         end
         FN_RM_DATE: begin
            pos = find_date(key);
            if (pos < shadow_used) drop_date_at(pos);
            else r.status = ST_NOTFOUND;
         end
         FN_LOOKUP: begin
            r.found = (find_date(key) < shadow_used);
         end
         FN_READ: begin
            if (int'(c.slot) < shadow_used) begin
               e = shadow_dates[int'(c.slot)];
               r.day   = e[DAY_W-1:0];
               r.month = e[DAY_W +: MONTH_W];
               r.year  = e[DAY_W+MONTH_W +: YEAR_W];
            end else begin
               r.status = ST_NOTFOUND;
            end
         end
         FN_RM_IDX: begin
            if (int'(c.slot) < shadow_used) drop_date_at(int'(c.slot));
            else r.status = ST_NOTFOUND;
         end
         default: begin
         end
      endcase
      r.used = CNT_W'(shadow_used);
      return r;
   endfunction

   // ---- stimulus helpers ----

   function automatic date_cmd_type mk_cmd(logic [2:0] f, int d, int m, int y, int s);
      date_cmd_type c;
      c.func  = f;
      c.day   = DAY_W'(d);
      c.month = MONTH_W'(m);
      c.year  = YEAR_W'(y);
      c.slot  = CNT_W'(s);
      return c;
   endfunction

   function automatic date_rsp_type mk_rsp(status_type st, bit fnd, int d, int m, int y,
                                           int used);
      date_rsp_type r;
      r.status = st;
      r.found  = fnd;
      r.day    = DAY_W'(d);
      r.month  = MONTH_W'(m);
      r.year   = YEAR_W'(y);
      r.used   = CNT_W'(used);
      return r;
   endfunction

   function automatic void add_row(date_cmd_type c, bit typed, date_rsp_type r);
      cmd_row_type row;
      row.cmd   = c;
      row.typed = typed;
      row.rsp   = r;
      cmd_rows.push_back(row);
   endfunction

   // copy a stored date into the operand fields
   function automatic void pick_stored(inout date_cmd_type c);
      logic [DATE_W-1:0] e;
      if (shadow_used == 0) return;
      e = shadow_dates[$urandom_range(0, shadow_used - 1)];
      c.day   = e[DAY_W-1:0];
      c.month = e[DAY_W +: MONTH_W];
      c.year  = e[DAY_W+MONTH_W +: YEAR_W];
   endfunction

   function automatic date_cmd_type rand_cmd(bit filling);
      date_cmd_type c;
      int           r;
      int           t_add, t_look, t_read, t_rmd, t_rmi;
      c.func  = FN_LOOKUP;
      c.day   = DAY_W'($urandom);
      c.month = MONTH_W'($urandom);
      c.year  = YEAR_W'($urandom);
      c.slot  = CNT_W'($urandom);
      if (filling) begin
         t_add = 60; t_look = 70; t_read = 78; t_rmd = 86; t_rmi = 96;
      end else begin
         t_add = 20; t_look = 30; t_read = 40; t_rmd = 70; t_rmi = 97;
      end
      r = $urandom_range(0, 99);
      if (r < t_add) begin
         c.func = FN_ADD;
         r = $urandom_range(0, 9);
         if (r < 8) begin
            c.day   = DAY_W'($urandom_range(1, 31));
            c.month = MONTH_W'($urandom_range(1, 12));
            c.year  = YEAR_W'($urandom_range(0, 99));
         end else if (r == 8) begin
            pick_stored(c);
         end else begin
            // force one field of the date out of range; the others stay random
            case ($urandom_range(0, 2))
               0: c.day = '0;
               1: begin
                  c.month = MONTH_W'($urandom_range(0, 3));
                  if (c.month != '0) c.month = c.month + MONTH_W'(12);
               end
               default: c.year = YEAR_W'($urandom_range(100, 127));
            endcase
         end
      end else if (r < t_rmd && r >= t_read || r < t_look) begin
         c.func = (r < t_look) ? FN_LOOKUP : FN_RM_DATE;
         if ($urandom_range(0, 9) < 6) pick_stored(c);
      end else if (r < t_read || r < t_rmi) begin
         c.func = (r < t_read) ? FN_READ : FN_RM_IDX;
         if ($urandom_range(0, 9) < 7)
            c.slot = CNT_W'($urandom_range(0, (shadow_used > 0) ? shadow_used - 1 : 0));
      end else begin
         c.func = 3'($urandom_range(FN_SPARE_MIN, FN_SPARE_MAX));
      end
      return c;
   endfunction

   // ---- driver ----

   task automatic issue_cmd(date_cmd_type c, bit typed, date_rsp_type typed_rsp, int gap);
      date_rsp_type predicted;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     <= 1'b1;
      req_func  <= c.func;
      req_day   <= c.day;
      req_month <= c.month;
      req_year  <= c.year;
      req_slot  <= c.slot;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_date_cmd(c);
      pending_rsps.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // ---- response checker ----

   always @(posedge clock) begin
      date_rsp_type want;
      date_rsp_type got;
      if (!reset && rsp_valid) begin
         got.status = status_type'(rsp_status);
         got.found  = rsp_found;
         got.day    = rsp_out_day;
         got.month  = rsp_out_month;
         got.year   = rsp_out_year;
         got.used   = rsp_entries_used;
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: response with none outstanding: status %0d used %0d",
                        $realtime, rsp_status, rsp_entries_used);
         end else begin
            want = pending_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("%0t: mismatch exp status %0d found %0d date %0d/%0d/%0d used %0d",
                           $realtime, want.status, want.found, want.day, want.month,
                           want.year, want.used);
                  $display("%0t: mismatch got status %0d found %0d date %0d/%0d/%0d used %0d",
                           $realtime, rsp_status, rsp_found, rsp_out_day,
                           rsp_out_month, rsp_out_year, rsp_entries_used);
               end
            end
         end
      end
   end

   // ---- watchdog: no beat on either side for too long ----

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // ---- main sequence ----

   initial begin
      date_rsp_type none;
      date_cmd_type c;
      int           done_items;
      int           next_phase_at;
      bit           filling;
      bit           no_gaps;
      none = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table
      add_row(mk_cmd(FN_LOOKUP, 1, 1, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 0, 0));
      add_row(mk_cmd(FN_READ, 0, 0, 0, 0), 1, mk_rsp(ST_NOTFOUND, 0, 0, 0, 0, 0));
      add_row(mk_cmd(FN_RM_IDX, 0, 0, 0, 63), 1, mk_rsp(ST_NOTFOUND, 0, 0, 0, 0, 0));
      add_row(mk_cmd(FN_RM_DATE, 31, 12, 99, 0), 1, mk_rsp(ST_NOTFOUND, 0, 0, 0, 0, 0));
      // invalid dates on add
      add_row(mk_cmd(FN_ADD, 0, 1, 0, 0), 1, mk_rsp(ST_INVALID, 0, 0, 0, 0, 0));
      add_row(mk_cmd(FN_ADD, 1, 13, 0, 0), 1, mk_rsp(ST_INVALID, 0, 0, 0, 0, 0));
      add_row(mk_cmd(FN_ADD, 1, 0, 0, 0), 1, mk_rsp(ST_INVALID, 0, 0, 0, 0, 0));
      add_row(mk_cmd(FN_ADD, 1, 1, 100, 0), 1, mk_rsp(ST_INVALID, 0, 0, 0, 0, 0));
      add_row(mk_cmd(FN_ADD, 31, 15, 127, 63), 1, mk_rsp(ST_INVALID, 0, 0, 0, 0, 0));
      // extremes, duplicate, reads
      add_row(mk_cmd(FN_ADD, 31, 12, 99, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 0, 1));
      add_row(mk_cmd(FN_ADD, 1, 1, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 0, 2));
      add_row(mk_cmd(FN_ADD, 31, 12, 99, 0), 1, mk_rsp(ST_PRESENT, 0, 0, 0, 0, 2));
      add_row(mk_cmd(FN_READ, 0, 0, 0, 1), 1, mk_rsp(ST_OK, 0, 1, 1, 0, 2));
      add_row(mk_cmd(FN_READ, 0, 0, 0, 0), 1, mk_rsp(ST_OK, 0, 31, 12, 99, 2));
      add_row(mk_cmd(FN_LOOKUP, 31, 12, 99, 0), 1, mk_rsp(ST_OK, 1, 0, 0, 0, 2));
      // lookup and remove by date take dates that add would reject
      add_row(mk_cmd(FN_LOOKUP, 0, 15, 127, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 0, 2));
      add_row(mk_cmd(FN_RM_DATE, 0, 0, 0, 0), 1, mk_rsp(ST_NOTFOUND, 0, 0, 0, 0, 2));
      // unused codes leave the table alone
      add_row(mk_cmd(FN_SPARE_MIN, 31, 15, 127, 63), 1, mk_rsp(ST_OK, 0, 0, 0, 0, 2));
      add_row(mk_cmd(FN_SPARE_MAX, 5, 5, 5, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 0, 2));
      // compaction
      add_row(mk_cmd(FN_ADD, 15, 6, 50, 0), 0, none);
      add_row(mk_cmd(FN_RM_IDX, 0, 0, 0, 0), 0, none);
      add_row(mk_cmd(FN_READ, 0, 0, 0, 0), 0, none);
      add_row(mk_cmd(FN_RM_DATE, 1, 1, 0, 0), 0, none);
      add_row(mk_cmd(FN_READ, 0, 0, 0, 1), 0, none);
      add_row(mk_cmd(FN_RM_IDX, 0, 0, 0, 0), 0, none);

      foreach (cmd_rows[i])
         issue_cmd(cmd_rows[i].cmd, cmd_rows[i].typed, cmd_rows[i].rsp,
                   $urandom_range(0, MAX_GAP));
      wait_drained();

      done_items    = 0;
      next_phase_at = 0;
      filling       = 1'b0;
      no_gaps       = 1'b0;
      while (done_items < RAND_ITEMS) begin
         if (done_items == next_phase_at) begin
            // hold off until no response is outstanding, then flip direction
            wait_drained();
            next_phase_at += PHASE_ITEMS;
            filling = !filling;
            no_gaps = ($urandom_range(0, 3) == 0);
         end
         c = rand_cmd(filling);
         issue_cmd(c, 0, none, no_gaps ? 0 : $urandom_range(0, MAX_GAP));
         if (c.func < FN_SPARE_MIN) done_items++;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_rsps.size() != 0) mismatches++;
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
